@@ sv/wdtw_pkg.sv @@
`default_nettype none
package wdtw_pkg;

    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_LENGTH     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_LENGTH = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEEPNESS        = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WEIGHT       = 8'd3;

    localparam int unsigned COST_W   = 48;
    localparam int unsigned DIST_W   = 32;
    localparam int unsigned LEN_W    = 11;
    localparam int unsigned WEIGHT_W = 24;
    localparam int unsigned DEN_W    = 18;
    localparam int unsigned REM_W    = 17;

    localparam logic [COST_W-1:0] INF48     = {COST_W{1'b1}};
    localparam logic [16:0]       LOG2E_Q16 = 17'd94548;

    // one stage of the restoring divider chain
    typedef struct packed {
        logic [REM_W-1:0]    rem;
        logic [WEIGHT_W-1:0] word;  // remaining dividend bits on top, quotient bits below
        logic [DEN_W-1:0]    den;
    } div_t;

    // round(65536 * 2^(-q/16))
    function automatic logic [16:0] pow2_neg(input logic [4:0] q);
        logic [16:0] r;
        case (q)
            5'd0:    r = 17'd65536;
            5'd1:    r = 17'd62757;
            5'd2:    r = 17'd60097;
            5'd3:    r = 17'd57549;
            5'd4:    r = 17'd55109;
            5'd5:    r = 17'd52773;
            5'd6:    r = 17'd50535;
            5'd7:    r = 17'd48393;
            5'd8:    r = 17'd46341;
            5'd9:    r = 17'd44376;
            5'd10:   r = 17'd42495;
            5'd11:   r = 17'd40693;
            5'd12:   r = 17'd38968;
            5'd13:   r = 17'd37316;
            5'd14:   r = 17'd35734;
            5'd15:   r = 17'd34219;
            5'd16:   r = 17'd32768;
            default: r = 17'd32768;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ sv/wdtw_ram.sv @@
`default_nettype none
module wdtw_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ sv/wdtw_div_cell.sv @@
`default_nettype none
module wdtw_div_cell
    import wdtw_pkg::*;
(
    input  wire logic aclk,
    input  wire div_t d_in,
    output div_t      d_out
);
    logic [DEN_W-1:0] trial;
    logic             fits;
    div_t             d_next;

    always_comb begin
        trial = {d_in.rem, d_in.word[WEIGHT_W-1]};
        fits  = trial >= d_in.den;
        d_next.den  = d_in.den;
        d_next.rem  = fits ? REM_W'(trial - d_in.den) : REM_W'(trial);
        d_next.word = {d_in.word[WEIGHT_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        d_out <= d_next;
    end
endmodule
`default_nettype wire

@@ sv/weighted_dtw_accumulator_core.sv @@
// Weighted DTW accumulator.
// Input channel s_*: one frame distance (Q16.16) per grid cell, row-major order
// over an input_length by reference_length grid. Output channel m_*: one item per
// cell with the accumulated cost (Q32.16, all ones = infinity), the cell's row and
// column (from 1) and a flag on the final cell of the grid.
// Config channel cfg_*: index 0 input_length, 1 reference_length, 2 steepness (Q4.12),
// 3 max_weight (Q8.8); other indices are ignored. cfg_ready is always high; write
// only between items.
// Each item passes through the states X, U, P, E, DIV and ACC before m_valid, and the next
// item is accepted once the result is in the output register: one item at a time.
// The DIV state runs the 24-cell restoring divider chain that forms the logistic
// weight; X, U, P and E do the weight arithmetic and ACC the cost update.
// The output register lets a new item in while a result waits; if the receiver
// stalls, the next item holds in its final step until the register frees up.
// Reset (synchronous, aresetn low) restores default config and starts a new grid
// at cell (1,1); the row store needs no clearing since row 1 never reads it.
`default_nettype none
module weighted_dtw_accumulator_core
    import wdtw_pkg::*;
#(
    parameter int unsigned MAX_FRAMES = 1024
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [DIST_W-1:0]    s_frame_distance,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic      [COST_W-1:0]    m_accumulated_cost,
    output logic      [LEN_W-1:0]     m_row_index,
    output logic      [LEN_W-1:0]     m_column_index,
    output logic                      m_last_cell,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data
);
    localparam int unsigned CW  = $clog2(MAX_FRAMES + 1);
    localparam int unsigned AW  = $clog2(MAX_FRAMES);
    localparam int unsigned DW  = CW + 2;
    localparam int unsigned XW  = DW + 17;
    localparam int unsigned UW  = XW + 5;
    localparam int unsigned KW  = UW - 16;
    localparam int unsigned DIV_STEPS = WEIGHT_W;
    localparam int unsigned DCW = $clog2(DIV_STEPS + 2);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_X    = 3'd1;
    localparam logic [2:0] ST_U    = 3'd2;
    localparam logic [2:0] ST_P    = 3'd3;
    localparam logic [2:0] ST_E    = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_ACC  = 3'd6;

    logic [2:0]  state_reg;
    logic [10:0] in_len_reg, ref_len_reg;
    logic [15:0] steep_reg, wmax_reg;

    logic [CW-1:0]     row_reg, col_reg;
    logic [COST_W-1:0] left_reg, diag_reg;

    logic [DIST_W-1:0]      dist_reg;
    logic signed [DW-1:0]   d_reg;
    logic signed [XW-1:0]   x_reg;
    logic [XW-1:0]          ax_reg;
    logic                   xneg_reg;
    logic [UW-1:0]          u_reg;
    logic [16:0]            a_reg;
    logic [23:0]            dp_reg;
    logic                   kbig_reg;
    logic [4:0]             k5_reg;
    logic [39:0]            num_reg;
    logic [DEN_W-1:0]       den_reg;
    logic [DCW-1:0]         dcnt_reg;
    logic [39:0]            cost_reg;

    logic [COST_W-1:0] m_cost_reg;
    logic [LEN_W-1:0]  m_row_reg, m_col_reg;
    logic              m_last_reg, m_valid_reg;

    function automatic logic [CW-1:0] eff_len(input logic [10:0] v);
        logic [31:0] t;
        t = 32'(v);
        if (t == 32'd0) begin
            t = 32'd1;
        end else if (t > 32'(MAX_FRAMES)) begin
            t = 32'(MAX_FRAMES);
        end
        return CW'(t);
    endfunction

    logic [CW-1:0] n_eff, m_eff, absdiff, half;
    logic [CW:0]   nm_sum;
    assign n_eff   = eff_len(in_len_reg);
    assign m_eff   = eff_len(ref_len_reg);
    assign absdiff = (row_reg > col_reg) ? CW'(row_reg - col_reg) : CW'(col_reg - row_reg);
    assign nm_sum  = {1'b0, n_eff} + {1'b0, m_eff};
    assign half    = nm_sum[CW:1];

    logic accept;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // row store
    logic [COST_W-1:0] above_raw;
    logic [AW-1:0]     row_addr;
    logic              out_free, finish;
    logic [COST_W-1:0] acc;
    assign row_addr = AW'(col_reg - CW'(1));
    assign out_free = !m_valid_reg || m_ready;
    assign finish   = (state_reg == ST_ACC) && out_free;

    wdtw_ram #(.WIDTH(COST_W), .DEPTH(MAX_FRAMES)) u_row_ram (
        .clk   (aclk),
        .we    (finish),
        .waddr (row_addr),
        .wdata (acc),
        .raddr (row_addr),
        .rdata (above_raw)
    );

    // divider chain
    div_t chain [DIV_STEPS+1];
    assign chain[0].rem  = REM_W'(num_reg[39:24]);
    assign chain[0].word = num_reg[23:0];
    assign chain[0].den  = den_reg;

    for (genvar c = 0; c < DIV_STEPS; c++) begin : g_div
        wdtw_div_cell u_cell (
            .aclk  (aclk),
            .d_in  (chain[c]),
            .d_out (chain[c+1])
        );
    end

    logic [WEIGHT_W-1:0] weight;
    logic [55:0]         wprod;
    assign weight = chain[DIV_STEPS].word;
    assign wprod  = 56'(weight) * 56'(dist_reg);

    // weight arithmetic
    logic [UW+16:0] uprod;
    logic [3:0]     q;
    logic [16:0]    ta, tb;
    logic [16:0]    p, e;
    logic [32:0]    we_prod;
    assign uprod = (UW+17)'(ax_reg) * (UW+17)'(LOG2E_Q16);
    assign q     = u_reg[15:12];
    assign ta    = pow2_neg({1'b0, q});
    assign tb    = pow2_neg(5'({1'b0, q}) + 5'd1);
    assign p     = a_reg - 17'(dp_reg >> 12);
    assign e     = kbig_reg ? 17'd0 : (p >> k5_reg);
    assign we_prod = 33'(wmax_reg) * 33'(e);

    // cost update
    logic [COST_W-1:0] above, best;
    logic [COST_W:0]   sum;
    logic              last_col, last_row;
    always_comb begin
        above = (row_reg == CW'(1)) ? INF48 : above_raw;
        best  = above;
        if (left_reg < best) best = left_reg;
        if (diag_reg < best) best = diag_reg;
        sum = {1'b0, best} + (COST_W+1)'(cost_reg);
        if (best == INF48 || sum >= {1'b0, INF48}) begin
            acc = INF48;
        end else begin
            acc = sum[COST_W-1:0];
        end
        last_col = col_reg >= m_eff;
        last_row = row_reg >= n_eff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            in_len_reg  <= 11'd1;
            ref_len_reg <= 11'd1;
            steep_reg   <= 16'd4096;
            wmax_reg    <= 16'd256;
            row_reg     <= CW'(1);
            col_reg     <= CW'(1);
            left_reg    <= INF48;
            diag_reg    <= '0;
            m_valid_reg <= 1'b0;
            dcnt_reg    <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_INPUT_LENGTH:     in_len_reg  <= cfg_data[10:0];
                    REG_REFERENCE_LENGTH: ref_len_reg <= cfg_data[10:0];
                    REG_STEEPNESS:        steep_reg   <= cfg_data;
                    REG_MAX_WEIGHT:       wmax_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: if (accept) state_reg <= ST_X;
                ST_X:    state_reg <= ST_U;
                ST_U:    state_reg <= ST_P;
                ST_P:    state_reg <= ST_E;
                ST_E: begin
                    state_reg <= ST_DIV;
                    dcnt_reg  <= '0;
                end
                ST_DIV: begin
                    // load the chain registers, then wait while the item passes through every cell
                    if (dcnt_reg == DCW'(DIV_STEPS + 1)) begin
                        state_reg <= ST_ACC;
                    end else begin
                        dcnt_reg <= dcnt_reg + DCW'(1);
                    end
                end
                ST_ACC: begin
                    if (out_free) begin
                        state_reg   <= ST_IDLE;
                        if (!last_col) begin
                            col_reg  <= col_reg + CW'(1);
                            left_reg <= acc;
                            diag_reg <= above;
                        end else begin
                            col_reg  <= CW'(1);
                            left_reg <= INF48;
                            if (last_row) begin
                                row_reg  <= CW'(1);
                                diag_reg <= '0;
                            end else begin
                                row_reg  <= row_reg + CW'(1);
                                diag_reg <= INF48;
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            dist_reg <= s_frame_distance;
            d_reg    <= $signed({2'b00, absdiff}) - $signed({2'b00, half});
        end
        if (state_reg == ST_X) begin
            x_reg <= XW'(d_reg) * $signed(XW'({1'b0, steep_reg}));
        end
        if (state_reg == ST_U) begin
            xneg_reg <= x_reg < 0;
            ax_reg   <= (x_reg < 0) ? XW'(-x_reg) : XW'(x_reg);
        end
        if (state_reg == ST_P) begin
            u_reg <= UW'(uprod >> 12);
        end
        if (state_reg == ST_E) begin
            a_reg    <= ta;
            dp_reg   <= 24'(ta - tb) * 24'(u_reg[11:0]);
            kbig_reg <= u_reg[UW-1:16] >= KW'(32);
            k5_reg   <= u_reg[20:16];
        end
        if (state_reg == ST_DIV && dcnt_reg == DCW'(0)) begin
            den_reg <= DEN_W'(17'd65536) + DEN_W'(e);
            num_reg <= xneg_reg ? {we_prod[31:0], 8'd0} : {wmax_reg, 24'd0};
        end
        if (state_reg == ST_DIV && dcnt_reg == DCW'(DIV_STEPS + 1)) begin
            cost_reg <= wprod[55:16];
        end
        if (finish) begin
            m_cost_reg <= acc;
            m_row_reg  <= LEN_W'(row_reg);
            m_col_reg  <= LEN_W'(col_reg);
            m_last_reg <= last_col && last_row;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_accumulated_cost = m_cost_reg;
    assign m_row_index        = m_row_reg;
    assign m_column_index     = m_col_reg;
    assign m_last_cell        = m_last_reg;

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_X)
        else $error("accepted item did not start processing");
    a_stall_holds_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ACC && m_valid_reg && !m_ready) |=> state_reg == ST_ACC)
        else $error("result overwrote a pending output item");
    a_dist_latched: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> dist_reg == $past(s_frame_distance))
        else $error("frame distance not captured on accept");
    a_finish_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        finish |=> m_valid_reg)
        else $error("finished item not presented");
endmodule
`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none
module tb;
    import wdtw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FRAMES = 1024;
    localparam int unsigned FRAME_AW = $clog2(FRAMES);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_INDEX = 8'hFF;

    typedef struct {
        logic [COST_W-1:0] cost;
        logic [LEN_W-1:0]  row;
        logic [LEN_W-1:0]  col;
        logic              last;
    } cell_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [DIST_W-1:0]    s_frame_distance;
    logic                 m_valid;
    logic                 m_ready;
    logic [COST_W-1:0]    m_accumulated_cost;
    logic [LEN_W-1:0]     m_row_index;
    logic [LEN_W-1:0]     m_column_index;
    logic                 m_last_cell;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    weighted_dtw_accumulator_core #(.MAX_FRAMES(FRAMES)) i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_frame_distance  (s_frame_distance),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_accumulated_cost(m_accumulated_cost),
        .m_row_index       (m_row_index),
        .m_column_index    (m_column_index),
        .m_last_cell       (m_last_cell),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // predictor state
    logic [COST_W-1:0] row_costs [FRAMES];
    logic [COST_W-1:0] left_acc;
    logic [COST_W-1:0] diag_acc;
    int unsigned       cur_row;
    int unsigned       cur_col;
    logic [LEN_W-1:0]  cfg_n;
    logic [LEN_W-1:0]  cfg_m;
    logic [15:0]       cfg_g;
    logic [15:0]       cfg_w;

    int unsigned pow2_tab [0:16] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535,
                                     48393, 46341, 44376, 42495, 40693, 38968, 37316,
                                     35734, 34219, 32768};

    cell_result_t expected_cells [$];
    int           errors;
    bit           no_idle;
    int           rx_hold;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("weighted_dtw_accumulator_core: mismatch");
        $finish;
    end

    function automatic int unsigned clamp_len(logic [LEN_W-1:0] v);
        if (v == 0) return 1;
        if (v > FRAMES) return FRAMES;
        return 32'(v);
    endfunction

    function automatic logic [63:0] logistic_weight(int unsigned i, int unsigned j,
                                                    int unsigned n, int unsigned m);
        longint      d;
        longint      x;
        logic [63:0] ax;
        logic [63:0] u;
        logic [63:0] k;
        logic [63:0] e;
        logic [63:0] den;
        int unsigned f;
        int unsigned a;
        int unsigned b;
        int unsigned p;
        d = longint'(i > j ? i - j : j - i) - longint'((n + m) / 2);
        x = d * longint'(cfg_g);
        ax = x < 0 ? 64'(-x) : 64'(x);
        u = (ax * 64'd94548) >> 12;
        k = u >> 16;
        f = 32'(u[15:0]);
        a = pow2_tab[5'(f >> 12)];
        b = pow2_tab[5'((f >> 12) + 1)];
        p = a - int'((64'(a - b) * 64'(f & 32'hFFF)) >> 12);
        e = k >= 32 ? 64'd0 : (64'(p) >> k);
        den = 64'd65536 + e;
        if (x >= 0) return (64'(cfg_w) << 24) / den;
        return ((64'(cfg_w) * e) << 8) / den;
    endfunction

    function automatic cell_result_t model_cell_cost(logic [DIST_W-1:0] distance);
        cell_result_t r;
        int unsigned  n;
        int unsigned  m;
        logic [63:0]  above;
        logic [63:0]  best;
        logic [63:0]  acc;
        logic [63:0]  cost;
        bit           end_col;
        bit           end_row;
        n = clamp_len(cfg_n);
        m = clamp_len(cfg_m);
        above = (cur_row == 1) ? 64'(INF48)
                               : 64'(row_costs[FRAME_AW'((cur_col - 1) % FRAMES)]);
        cost = (logistic_weight(cur_row, cur_col, n, m) * 64'(distance)) >> 16;
        best = above;
        if (64'(left_acc) < best) best = 64'(left_acc);
        if (64'(diag_acc) < best) best = 64'(diag_acc);
        if (best >= 64'(INF48)) acc = 64'(INF48);
        else begin
            acc = best + cost;
            if (acc > 64'(INF48)) acc = 64'(INF48);
        end
        row_costs[FRAME_AW'((cur_col - 1) % FRAMES)] = acc[COST_W-1:0];
        end_col = cur_col >= m;
        end_row = cur_row >= n;
        r.cost = acc[COST_W-1:0];
        r.row  = cur_row[LEN_W-1:0];
        r.col  = cur_col[LEN_W-1:0];
        r.last = end_col && end_row;
        if (!end_col) begin
            cur_col  = cur_col + 1;
            left_acc = acc[COST_W-1:0];
            diag_acc = above[COST_W-1:0];
        end else begin
            cur_col  = 1;
            left_acc = INF48;
            if (end_row) begin
                cur_row  = 1;
                diag_acc = '0;
            end else begin
                cur_row  = cur_row + 1;
                diag_acc = INF48;
            end
        end
        return r;
    endfunction

    // results
    always @(posedge aclk) begin
        cell_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_cells.size() == 0) begin
                $error("unexpected result item: cost %0h row %0d col %0d",
                       m_accumulated_cost, m_row_index, m_column_index);
                errors++;
            end else begin
                want = expected_cells.pop_front();
                if (m_accumulated_cost !== want.cost) begin
                    $error("accumulated_cost: expected %0h, got %0h", want.cost,
                           m_accumulated_cost);
                    errors++;
                end
                if (m_row_index !== want.row) begin
                    $error("row_index: expected %0d, got %0d", want.row, m_row_index);
                    errors++;
                end
                if (m_column_index !== want.col) begin
                    $error("column_index: expected %0d, got %0d", want.col, m_column_index);
                    errors++;
                end
                if (m_last_cell !== want.last) begin
                    $error("last_cell: expected %0b, got %0b", want.last, m_last_cell);
                    errors++;
                end
            end
        end
    end

    // receiver idling and long hold-off
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if (no_idle) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= 8);
        end
    end

    task automatic send_distance(logic [DIST_W-1:0] distance);
        if (!no_idle && $urandom_range(0, 99) < 8) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_frame_distance <= distance;
        do @(posedge aclk); while (!s_ready);
        expected_cells.push_back(model_cell_cost(distance));
    endtask

    task automatic drain();
        @(posedge aclk);
        s_valid <= 1'b0;
        while (expected_cells.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_INPUT_LENGTH:     cfg_n = data[LEN_W-1:0];
            REG_REFERENCE_LENGTH: cfg_m = data[LEN_W-1:0];
            REG_STEEPNESS:        cfg_g = data;
            REG_MAX_WEIGHT:       cfg_w = data;
            default: ;
        endcase
    endtask

    // length write with junk in the bits above the register
    task automatic write_len(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] len);
        write_reg(idx, {5'($urandom), len});
    endtask

    function automatic logic [DIST_W-1:0] pick_distance();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 65535);
            default: return $urandom;
        endcase
    endfunction

    // runs cells until the counters are back at the origin
    task automatic finish_grid(bit fixed, logic [DIST_W-1:0] distance);
        do send_distance(fixed ? distance : pick_distance());
        while (!(cur_row == 1 && cur_col == 1));
    endtask

    task automatic test_defaults();
        send_distance('0);
        send_distance('1);
        send_distance(32'hAAAA_5555);
        send_distance(32'h5555_AAAA);
        drain();
    endtask

    task automatic test_directed();
        write_len(REG_INPUT_LENGTH, 11'd3);
        write_len(REG_REFERENCE_LENGTH, 11'd4);
        write_reg(REG_STEEPNESS, 16'd0);
        write_reg(REG_MAX_WEIGHT, 16'hFFFF);
        finish_grid(1'b1, '1);
        drain();
        write_reg(REG_STEEPNESS, 16'hFFFF);
        write_reg(REG_MAX_WEIGHT, 16'd0);
        finish_grid(1'b0, '0);
        drain();
        write_reg(REG_MAX_WEIGHT, 16'h0180);
        // shrink the row mid-grid: counters carry on and wrap at the new bound
        repeat (5) send_distance(pick_distance());
        drain();
        write_len(REG_REFERENCE_LENGTH, 11'd2);
        finish_grid(1'b0, '0);
        drain();
        // zero lengths mean one
        write_len(REG_INPUT_LENGTH, 11'd0);
        write_len(REG_REFERENCE_LENGTH, 11'd0);
        write_reg(REG_UNUSED, 16'h1234);
        write_reg(REG_TOP_INDEX, 16'hFFFF);
        finish_grid(1'b1, 32'h8000_0001);
        drain();
    endtask

    // lengths above the maximum clamp; max distance drives the sum to saturation
    task automatic test_long_grids();
        write_reg(REG_STEEPNESS, 16'd1);
        write_reg(REG_MAX_WEIGHT, 16'hFFFF);
        write_len(REG_INPUT_LENGTH, 11'd1);
        write_len(REG_REFERENCE_LENGTH, 11'h7FF);
        finish_grid(1'b1, '1);
        drain();
    endtask

    task automatic test_backpressure();
        write_len(REG_INPUT_LENGTH, 11'd5);
        write_len(REG_REFERENCE_LENGTH, 11'd6);
        write_reg(REG_STEEPNESS, 16'h1000);
        write_reg(REG_MAX_WEIGHT, 16'h0100);
        rx_hold = 400;
        finish_grid(1'b0, '0);
        drain();
    endtask

    task automatic test_random();
        int sent;
        int phase;
        sent = 0;
        phase = 0;
        while (sent < 340) begin
            no_idle = (phase == 1 || phase == 2);
            if ($urandom_range(0, 9) == 0) begin
                write_len(REG_INPUT_LENGTH, 11'($urandom_range(1, 20)));
                write_len(REG_REFERENCE_LENGTH, 11'($urandom_range(1, 20)));
            end else begin
                write_len(REG_INPUT_LENGTH, 11'($urandom_range(1, 8)));
                write_len(REG_REFERENCE_LENGTH, 11'($urandom_range(1, 8)));
            end
            case ($urandom_range(0, 3))
                0: write_reg(REG_STEEPNESS, 16'($urandom));
                1: write_reg(REG_STEEPNESS, 16'($urandom_range(0, 8192)));
                default: write_reg(REG_STEEPNESS, 16'($urandom_range(0, 1024)));
            endcase
            write_reg(REG_MAX_WEIGHT, 16'($urandom));
            repeat ($urandom_range(1, 3)) begin
                finish_grid(1'b0, '0);
                sent += clamp_len(cfg_n) * clamp_len(cfg_m);
            end
            drain();
            phase++;
        end
        no_idle = 1'b0;
    endtask

    initial begin
        errors           = 0;
        no_idle          = 1'b0;
        rx_hold          = 0;
        cur_row          = 1;
        cur_col          = 1;
        left_acc         = INF48;
        diag_acc         = '0;
        cfg_n            = 11'd1;
        cfg_m            = 11'd1;
        cfg_g            = 16'd4096;
        cfg_w            = 16'd256;
        aresetn          <= 1'b0;
        s_valid          <= 1'b0;
        s_frame_distance <= '0;
        m_ready          <= 1'b0;
        cfg_valid        <= 1'b0;
        cfg_index        <= '0;
        cfg_data         <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_defaults();
        test_directed();
        test_long_grids();
        test_backpressure();
        test_random();
        drain();
        if (errors == 0) begin
            $display("weighted_dtw_accumulator_core: match");
        end else begin
            $display("weighted_dtw_accumulator_core: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
sv/wdtw_pkg.sv
sv/wdtw_ram.sv
sv/wdtw_div_cell.sv
sv/weighted_dtw_accumulator_core.sv
tb/tb.sv
